@@ rtl/asf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asf_pkg: shared types and constants of the subtract-group alu
// command and response word layouts, opcodes, shift kinds, flag positions
// ----------------------------------------------------------------------------
package asf_pkg;

    localparam int REG_COUNT  = 16;
    localparam int WORD_WIDTH = 32;
    localparam int REG_AW     = $clog2(REG_COUNT);

    // opcodes
    localparam logic [1:0] OP_SUB  = 2'd0;
    localparam logic [1:0] OP_RSB  = 2'd1;
    localparam logic [1:0] OP_SBC  = 2'd2;
    localparam logic [1:0] OP_LOAD = 2'd3;

    // shift kinds
    localparam logic [2:0] SH_LSL = 3'd0;
    localparam logic [2:0] SH_LSR = 3'd1;
    localparam logic [2:0] SH_ASR = 3'd2;
    localparam logic [2:0] SH_ROR = 3'd3;
    localparam logic [2:0] SH_RRX = 3'd4;

    // flag bit positions in the status register
    localparam int FLAG_N_BIT = 3;
    localparam int FLAG_Z_BIT = 2;
    localparam int FLAG_C_BIT = 1;
    localparam int FLAG_V_BIT = 0;

    typedef struct packed {
        logic [1:0]  opcode;
        logic        use_immediate;
        logic [3:0]  dest_reg;
        logic [3:0]  first_reg;
        logic [3:0]  second_reg;
        logic [31:0] immediate;
        logic        set_flags;
        logic [2:0]  shift_kind;
        logic [5:0]  shift_amount;
    } cmd_t;

    typedef struct packed {
        logic [31:0] result_value;
        logic [3:0]  result_reg;
        logic        flags_updated;
        logic        flag_n;
        logic        flag_z;
        logic        flag_c;
        logic        flag_v;
    } rsp_t;

endpackage : asf_pkg
`default_nettype wire

@@ rtl/asf_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asf_ram: generic ram, one write port, two registered read ports
// a read at the address being written returns the old contents
// ----------------------------------------------------------------------------
module asf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]         rd_data_a,
    output logic      [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule : asf_ram
`default_nettype wire

@@ rtl/arm_subtract_alu_with_flags_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arm_subtract_alu_with_flags_core: sub / rsb / sbc execute unit with flags
// 16 x 32 register file, barrel-shifted second operand, n/z/c/v status
// ----------------------------------------------------------------------------
// The block executes one subtract-group instruction per word: SUB (rn - op2),
// RSB (op2 - rn), SBC (rn - op2 - not c) and a load that seeds a register with
// the immediate. op2 is the immediate or rm through the shifter (lsl, lsr, asr,
// ror, rrx; rrx shifts in the c flag). Every word writes rd and returns exactly
// one response word with the value, rd, whether the flags were written, and
// the four flags as they stand afterwards. It takes one word per cycle while
// the response side does not stall. The command is registered together with
// the register-file read, the alu sits between that stage and the response
// register. The register file is a two-read one-write ram; the write made at
// the same edge as a read is forwarded from a last-write register, and
// per-entry valid bits make never-written registers read as zero right after
// reset, so no clearing pass is needed. Stalls on the response side hold the
// pipe; the command side keeps taking words while the response register can
// be refilled in the same cycle.
// ----------------------------------------------------------------------------
module arm_subtract_alu_with_flags_core
    import asf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    output logic      cmd_ready,
    input  wire cmd_t cmd,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    // ------------------------------------------------------------------
    // pipeline control
    // ------------------------------------------------------------------
    logic                   exe_valid_reg;   // command stage holds a word
    cmd_t                   exe_cmd_reg;     // registered command
    logic                   rn_ok_reg;       // rn had been written at read time
    logic                   rm_ok_reg;       // rm had been written at read time
    logic                   rsp_valid_reg;
    rsp_t                   rsp_reg;

    logic [REG_COUNT-1:0]   written_reg;     // register-file entry valid bits
    logic [3:0]             flags_reg;       // n z c v

    // last write to the register file, for forwarding
    logic                   lw_valid_reg;
    logic [REG_AW-1:0]      lw_idx_reg;
    logic [WORD_WIDTH-1:0]  lw_data_reg;

    logic                   cmd_fire;
    logic                   exe_fire;        // alu result moves to the response register

    // ram read data
    logic [WORD_WIDTH-1:0]  rn_ram;
    logic [WORD_WIDTH-1:0]  rm_ram;

    // alu
    logic [WORD_WIDTH-1:0]  rn_val;
    logic [WORD_WIDTH-1:0]  rm_val;
    logic [WORD_WIDTH-1:0]  shifted;
    logic [WORD_WIDTH-1:0]  rot_src;
    logic [2*WORD_WIDTH-1:0] rot_pair;
    logic [WORD_WIDTH-1:0]  op2;
    logic [WORD_WIDTH-1:0]  add_x;
    logic [WORD_WIDTH-1:0]  add_y;
    logic                   add_cin;
    logic [WORD_WIDTH:0]    sum;
    logic [WORD_WIDTH-1:0]  result;
    logic                   do_flags;
    logic [3:0]             flags_next;
    rsp_t                   rsp_next;
    logic                   c_in;

    assign c_in      = flags_reg[FLAG_C_BIT];
    assign exe_fire  = exe_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign cmd_ready = !exe_valid_reg || exe_fire;
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ------------------------------------------------------------------
    // register file, read when the command is taken, written by the alu
    // ------------------------------------------------------------------
    asf_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (REG_COUNT)
    ) u_regfile (
        .clk       (clk),
        .wr_en     (exe_fire),
        .wr_addr   (exe_cmd_reg.dest_reg),
        .wr_data   (result),
        .rd_en     (cmd_fire),
        .rd_addr_a (cmd.first_reg),
        .rd_addr_b (cmd.second_reg),
        .rd_data_a (rn_ram),
        .rd_data_b (rm_ram)
    );

    // operand select: the most recent write wins, then ram, else reset zero
    always_comb
    begin
        if (lw_valid_reg && lw_idx_reg == exe_cmd_reg.first_reg)
        begin
            rn_val = lw_data_reg;
        end
        else if (rn_ok_reg)
        begin
            rn_val = rn_ram;
        end
        else
        begin
            rn_val = '0;
        end

        if (lw_valid_reg && lw_idx_reg == exe_cmd_reg.second_reg)
        begin
            rm_val = lw_data_reg;
        end
        else if (rm_ok_reg)
        begin
            rm_val = rm_ram;
        end
        else
        begin
            rm_val = '0;
        end
    end

    // ------------------------------------------------------------------
    // barrel shifter
    // ------------------------------------------------------------------
    assign rot_src  = rm_val;
    assign rot_pair = {rot_src, rot_src} >> exe_cmd_reg.shift_amount[4:0];

    always_comb
    begin
        shifted = rm_val;
        if (exe_cmd_reg.shift_amount != '0)
        begin
            case (exe_cmd_reg.shift_kind)
                SH_LSL:
                begin
                    shifted = exe_cmd_reg.shift_amount[5] ? '0
                            : rm_val << exe_cmd_reg.shift_amount[4:0];
                end
                SH_LSR:
                begin
                    shifted = exe_cmd_reg.shift_amount[5] ? '0
                            : rm_val >> exe_cmd_reg.shift_amount[4:0];
                end
                SH_ASR:
                begin
                    // amounts of 32 and up fill with the sign bit
                    if (exe_cmd_reg.shift_amount[5])
                    begin
                        shifted = {WORD_WIDTH{rm_val[WORD_WIDTH-1]}};
                    end
                    else
                    begin
                        shifted = WORD_WIDTH'($signed(rm_val)
                                  >>> exe_cmd_reg.shift_amount[4:0]);
                    end
                end
                SH_ROR:
                begin
                    shifted = rot_pair[WORD_WIDTH-1:0];
                end
                SH_RRX:
                begin
                    shifted = {c_in, rm_val[WORD_WIDTH-1:1]};
                end
                default:
                begin
                    shifted = rm_val;
                end
            endcase
        end
    end

    assign op2 = exe_cmd_reg.use_immediate ? exe_cmd_reg.immediate : shifted;

    // ------------------------------------------------------------------
    // add with carry
    // ------------------------------------------------------------------
    always_comb
    begin
        case (exe_cmd_reg.opcode)
            OP_RSB:
            begin
                add_x   = ~rn_val;
                add_y   = op2;
                add_cin = 1'b1;
            end
            OP_SBC:
            begin
                add_x   = rn_val;
                add_y   = ~op2;
                add_cin = c_in;
            end
            default:
            begin
                add_x   = rn_val;
                add_y   = ~op2;
                add_cin = 1'b1;
            end
        endcase
    end

    assign sum = {1'b0, add_x} + {1'b0, add_y} + {{WORD_WIDTH{1'b0}}, add_cin};

    always_comb
    begin
        result     = (exe_cmd_reg.opcode == OP_LOAD) ? exe_cmd_reg.immediate
                   : sum[WORD_WIDTH-1:0];
        do_flags   = exe_cmd_reg.set_flags && (exe_cmd_reg.opcode != OP_LOAD);
        flags_next = flags_reg;
        if (do_flags)
        begin
            flags_next[FLAG_N_BIT] = result[WORD_WIDTH-1];
            flags_next[FLAG_Z_BIT] = (result == '0);
            flags_next[FLAG_C_BIT] = sum[WORD_WIDTH];
            flags_next[FLAG_V_BIT] = (add_x[WORD_WIDTH-1] ^ result[WORD_WIDTH-1])
                                   & (add_y[WORD_WIDTH-1] ^ result[WORD_WIDTH-1]);
        end

        rsp_next.result_value  = result;
        rsp_next.result_reg    = exe_cmd_reg.dest_reg;
        rsp_next.flags_updated = do_flags;
        rsp_next.flag_n        = flags_next[FLAG_N_BIT];
        rsp_next.flag_z        = flags_next[FLAG_Z_BIT];
        rsp_next.flag_c        = flags_next[FLAG_C_BIT];
        rsp_next.flag_v        = flags_next[FLAG_V_BIT];
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exe_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            written_reg   <= '0;
            flags_reg     <= '0;
            lw_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd_fire)
            begin
                exe_valid_reg <= 1'b1;
            end
            else if (exe_fire)
            begin
                exe_valid_reg <= 1'b0;
            end

            if (exe_fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            if (exe_fire)
            begin
                written_reg[exe_cmd_reg.dest_reg] <= 1'b1;
                flags_reg                         <= flags_next;
                lw_valid_reg                      <= 1'b1;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            exe_cmd_reg <= cmd;
            rn_ok_reg   <= written_reg[cmd.first_reg];
            rm_ok_reg   <= written_reg[cmd.second_reg];
        end
        if (exe_fire)
        begin
            rsp_reg     <= rsp_next;
            lw_idx_reg  <= exe_cmd_reg.dest_reg;
            lw_data_reg <= result;
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_load_keeps_flags: assert property (@(posedge clk) disable iff (!rst_n)
        exe_fire && exe_cmd_reg.opcode == OP_LOAD
        |=> !rsp_reg.flags_updated && flags_reg == $past(flags_reg))
        else $error("load word touched the flags");

    a_no_setf_keeps_flags: assert property (@(posedge clk) disable iff (!rst_n)
        exe_fire && !exe_cmd_reg.set_flags |=> flags_reg == $past(flags_reg))
        else $error("flags changed without set_flags");

    a_rsp_dest: assert property (@(posedge clk) disable iff (!rst_n)
        exe_fire |=> rsp_reg.result_reg == $past(exe_cmd_reg.dest_reg)
                     && lw_idx_reg == rsp_reg.result_reg
                     && lw_data_reg == rsp_reg.result_value)
        else $error("response and forwarded write disagree");

    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        exe_fire && rsp_next.flags_updated
        |=> rsp_reg.flag_z == (rsp_reg.result_value == '0)
            && rsp_reg.flag_n == rsp_reg.result_value[WORD_WIDTH-1])
        else $error("n or z flag does not match result");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_ready |-> exe_valid_reg && rsp_valid_reg && !rsp_ready)
        else $error("command side stalled without a blocked response");

endmodule : arm_subtract_alu_with_flags_core
`default_nettype wire

@@ sim/alu_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu_result_checker: shadow execution and response check for the sub alu
// keeps its own register file and flags, predicts every response word and
// compares it field by field in order against what the core returns
// ----------------------------------------------------------------------------
module alu_result_checker
    import asf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    input  logic cmd_ready,
    input  cmd_t cmd,
    input  logic rsp_valid,
    input  logic rsp_ready,
    input  rsp_t rsp,
    output int   fail_count,
    output int   expected_left
);

    logic [31:0] shadow_regs [REG_COUNT];
    logic [3:0]  shadow_flags;
    rsp_t        expected_results [$];

    function automatic logic [31:0] shift_operand(input logic [31:0] v, input logic [2:0] kind,
                                                  input logic [5:0] amt, input logic cin);
        logic [31:0] r;
        logic [63:0] both;
        both = {v, v};
        r = v;
        if (amt != 0)
        begin
            case (kind)
                SH_LSL: r = (amt >= 32) ? 32'd0 : v << amt;
                SH_LSR: r = (amt >= 32) ? 32'd0 : v >> amt;
                SH_ASR:
                begin
                    // kept out of a mixed-sign conditional so the shift stays arithmetic
                    if (amt >= 32)
                        r = {32{v[31]}};
                    else
                        r = $signed(v) >>> amt;
                end
                // rotation wraps at 32, a multiple of 32 leaves it unshifted
                SH_ROR: r = 32'(both >> amt[4:0]);
                SH_RRX: r = {cin, v[31:1]};
                default: r = v;
            endcase
        end
        return r;
    endfunction

    // runs one instruction on the shadow state, returns the response it implies
    function automatic rsp_t execute_subtract(input cmd_t c);
        logic [31:0] op2;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] res;
        logic        cin;
        logic [32:0] sum;
        rsp_t        r;
        r = '0;
        if (c.opcode == OP_LOAD)
        begin
            res = c.immediate;
        end
        else
        begin
            op2 = c.use_immediate ? c.immediate
                : shift_operand(shadow_regs[c.second_reg], c.shift_kind, c.shift_amount,
                                shadow_flags[FLAG_C_BIT]);
            if (c.opcode == OP_RSB)
            begin
                x   = ~shadow_regs[c.first_reg];
                y   = op2;
                cin = 1'b1;
            end
            else
            begin
                x   = shadow_regs[c.first_reg];
                y   = ~op2;
                cin = (c.opcode == OP_SBC) ? shadow_flags[FLAG_C_BIT] : 1'b1;
            end
            sum = {1'b0, x} + {1'b0, y} + {32'd0, cin};
            res = sum[31:0];
            if (c.set_flags)
            begin
                shadow_flags[FLAG_N_BIT] = res[31];
                shadow_flags[FLAG_Z_BIT] = (res == 32'd0);
                shadow_flags[FLAG_C_BIT] = sum[32];
                shadow_flags[FLAG_V_BIT] = (x[31] ^ res[31]) & (y[31] ^ res[31]);
                r.flags_updated = 1'b1;
            end
        end
        shadow_regs[c.dest_reg] = res;
        r.result_value = res;
        r.result_reg   = c.dest_reg;
        r.flag_n       = shadow_flags[FLAG_N_BIT];
        r.flag_z       = shadow_flags[FLAG_Z_BIT];
        r.flag_c       = shadow_flags[FLAG_C_BIT];
        r.flag_v       = shadow_flags[FLAG_V_BIT];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        logic bad;
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
                shadow_regs[i] = '0;
            shadow_flags = '0;
            expected_results.delete();
            fail_count    = 0;
            expected_left = 0;
        end
        else
        begin
            // response first: a word accepted now can only belong to an older command
            if (rsp_valid && rsp_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: response word with nothing expected: %h", $time, rsp);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    bad = (want.result_value  !== rsp.result_value)
                       || (want.result_reg    !== rsp.result_reg)
                       || (want.flags_updated !== rsp.flags_updated)
                       || (want.flag_n        !== rsp.flag_n)
                       || (want.flag_z        !== rsp.flag_z)
                       || (want.flag_c        !== rsp.flag_c)
                       || (want.flag_v        !== rsp.flag_v);
                    if (bad)
                    begin
                        if (fail_count < 10)
                            $display({"%0t: mismatch exp value %h rd %0d upd %b nzcv %b%b%b%b,",
                                      " act value %h rd %0d upd %b nzcv %b%b%b%b"},
                                     $time, want.result_value, want.result_reg,
                                     want.flags_updated, want.flag_n, want.flag_z,
                                     want.flag_c, want.flag_v, rsp.result_value,
                                     rsp.result_reg, rsp.flags_updated, rsp.flag_n,
                                     rsp.flag_z, rsp.flag_c, rsp.flag_v);
                        fail_count++;
                    end
                end
            end
            if (cmd_valid && cmd_ready)
                expected_results.push_back(execute_subtract(cmd));
            expected_left = expected_results.size();
        end
    end

endmodule

@@ sim/tb_arm_subtract_alu_with_flags_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_arm_subtract_alu_with_flags_core: stimulus and verdict for the sub alu
// directed corner instructions, then random instruction streams with random
// idling on both channels, a long response stall and a full drain mid-run
// ----------------------------------------------------------------------------
module tb_arm_subtract_alu_with_flags_core;
    import asf_pkg::*;

    localparam int LONG_HOLD      = 300;   // response-side stall that backs up the pipe
    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any handshake before giving up
    localparam int CHUNK_WORDS    = 50;
    localparam int CHUNK_COUNT    = 12;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_ready;
    cmd_t cmd       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    int   fail_count;
    int   expected_left;
    int   idle_cycles = 0;

    // stretch controls shared by the two channel processes
    logic tx_burst     = 1'b0;  // sender offers words back to back
    logic rx_burst     = 1'b0;  // receiver never drops ready
    logic hold_pending = 1'b0;  // receiver takes one long stall next

    arm_subtract_alu_with_flags_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    alu_result_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .rsp           (rsp),
        .fail_count    (fail_count),
        .expected_left (expected_left)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // builds one command word
    function automatic cmd_t make_instr(input logic [1:0] op, input logic use_imm,
                                        input logic [3:0] rd, input logic [3:0] rn,
                                        input logic [3:0] rm, input logic [31:0] imm,
                                        input logic sf, input logic [2:0] kind,
                                        input logic [5:0] amt);
        cmd_t c;
        c.opcode        = op;
        c.use_immediate = use_imm;
        c.dest_reg      = rd;
        c.first_reg     = rn;
        c.second_reg    = rm;
        c.immediate     = imm;
        c.set_flags     = sf;
        c.shift_kind    = kind;
        c.shift_amount  = amt;
        return c;
    endfunction

    function automatic cmd_t random_instr();
        cmd_t c;
        // loads keep seeding the register file with fresh values
        c.opcode        = ($urandom_range(0, 6) == 0) ? OP_LOAD : 2'($urandom_range(0, 2));
        c.use_immediate = 1'($urandom_range(0, 1));
        c.dest_reg      = 4'($urandom_range(0, 15));
        c.first_reg     = 4'($urandom_range(0, 15));
        c.second_reg    = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 5))
            0:       c.immediate = 32'h0000_0000;
            1:       c.immediate = 32'hffff_ffff;
            2:       c.immediate = 32'h8000_0000;
            3:       c.immediate = 32'h7fff_ffff;
            default: c.immediate = $urandom;
        endcase
        c.set_flags = 1'($urandom_range(0, 1));
        // undefined shift kinds now and then, they pass the operand through
        c.shift_kind = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7))
                                                   : 3'($urandom_range(0, 4));
        case ($urandom_range(0, 5))
            0:       c.shift_amount = 6'd0;
            1:       c.shift_amount = 6'd32;
            2:       c.shift_amount = 6'($urandom_range(33, 63));
            default: c.shift_amount = 6'($urandom_range(1, 31));
        endcase
        return c;
    endfunction

    // offers one word, waits for it to be taken, then idles for a random gap;
    // called at a rising edge, returns at one
    task automatic issue(input cmd_t c);
        int gap;
        cmd_valid <= 1'b1;
        cmd       <= c;
        do @(posedge clk); while (!cmd_ready);
        gap = tx_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // response side: random stall before each word, one long hold on request
    initial
    begin
        int stall;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_pending)
            begin
                stall        = LONG_HOLD;
                hold_pending = 1'b0;
            end
            else
            begin
                stall = rx_burst ? 0 : $urandom_range(0, 15);
            end
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!rsp_valid);
        end
    end

    // watchdog: any handshake resets the count
    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("arm_subtract_alu_with_flags_core test failed");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // seed corner values; a load ignores set_flags
        issue(make_instr(OP_LOAD, 1'b1, 4'd1, 4'd0, 4'd0, 32'hffff_ffff, 1'b1, SH_LSL, 6'd0));
        issue(make_instr(OP_LOAD, 1'b1, 4'd2, 4'd0, 4'd0, 32'h8000_0000, 1'b1, SH_LSL, 6'd0));
        issue(make_instr(OP_LOAD, 1'b0, 4'd3, 4'd0, 4'd0, 32'h7fff_ffff, 1'b0, SH_LSL, 6'd0));
        issue(make_instr(OP_LOAD, 1'b1, 4'd15, 4'd0, 4'd0, 32'h1234_5678, 1'b1, SH_RRX, 6'd63));
        issue(make_instr(OP_LOAD, 1'b1, 4'd14, 4'd0, 4'd0, 32'h0000_0001, 1'b0, SH_LSL, 6'd0));
        // zero result, then a borrow, then signed overflow both ways
        issue(make_instr(OP_SUB, 1'b1, 4'd4, 4'd0, 4'd0, 32'h0, 1'b1, SH_LSL, 6'd0));
        issue(make_instr(OP_SUB, 1'b0, 4'd5, 4'd0, 4'd1, 32'h0, 1'b1, SH_LSL, 6'd0));
        issue(make_instr(OP_SBC, 1'b1, 4'd6, 4'd2, 4'd0, 32'h0, 1'b1, SH_LSL, 6'd0));
        issue(make_instr(OP_SUB, 1'b1, 4'd7, 4'd2, 4'd0, 32'h1, 1'b1, SH_LSL, 6'd0));
        issue(make_instr(OP_SBC, 1'b0, 4'd8, 4'd3, 4'd1, 32'h0, 1'b1, SH_LSL, 6'd0));
        issue(make_instr(OP_RSB, 1'b1, 4'd9, 4'd3, 4'd0, 32'h0, 1'b1, SH_LSL, 6'd0));
        // long shifts: asr fills with the sign, lsr and lsl clear
        issue(make_instr(OP_RSB, 1'b0, 4'd10, 4'd0, 4'd2, 32'h0, 1'b1, SH_ASR, 6'd40));
        issue(make_instr(OP_SUB, 1'b0, 4'd11, 4'd15, 4'd1, 32'h0, 1'b0, SH_LSR, 6'd32));
        // stack pointer as first operand
        issue(make_instr(OP_SUB, 1'b0, 4'd12, 4'd13, 4'd15, 32'h0, 1'b1, SH_LSL, 6'd63));
        issue(make_instr(OP_SUB, 1'b0, 4'd13, 4'd3, 4'd2, 32'h0, 1'b1, SH_LSL, 6'd1));
        // ror wraps modulo 32
        issue(make_instr(OP_SUB, 1'b0, 4'd4, 4'd0, 4'd15, 32'h0, 1'b1, SH_ROR, 6'd33));
        issue(make_instr(OP_RSB, 1'b0, 4'd5, 4'd0, 4'd15, 32'h0, 1'b0, SH_ROR, 6'd32));
        // rrx rotates one bit through carry whatever the amount, not at all at zero
        issue(make_instr(OP_SUB, 1'b0, 4'd6, 4'd0, 4'd15, 32'h0, 1'b0, SH_RRX, 6'd5));
        issue(make_instr(OP_RSB, 1'b0, 4'd7, 4'd0, 4'd15, 32'h0, 1'b1, SH_RRX, 6'd0));
        issue(make_instr(OP_SUB, 1'b0, 4'd8, 4'd14, 4'd2, 32'h0, 1'b1, SH_RRX, 6'd1));
        // undefined kind passes through, plus ordinary shifts, writes to r15
        issue(make_instr(OP_SBC, 1'b0, 4'd15, 4'd3, 4'd1, 32'h0, 1'b1, 3'd7, 6'd9));
        issue(make_instr(OP_SBC, 1'b0, 4'd9, 4'd1, 4'd2, 32'h0, 1'b1, SH_ASR, 6'd31));
        issue(make_instr(OP_SUB, 1'b0, 4'd10, 4'd2, 4'd1, 32'h0, 1'b1, SH_LSR, 6'd1));
        issue(make_instr(OP_RSB, 1'b0, 4'd11, 4'd1, 4'd14, 32'h0, 1'b1, SH_LSL, 6'd31));

        for (int chunk = 0; chunk < CHUNK_COUNT; chunk++)
        begin
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            if (chunk == 3)
            begin
                // long response stall while words keep coming: the core backs up
                hold_pending = 1'b1;
                tx_burst     = 1'b1;
            end
            if (chunk == 7)
            begin
                // sender pauses until the pipe has fully drained
                cmd_valid <= 1'b0;
                @(posedge clk);
                wait (expected_left == 0);
                @(posedge clk);
            end
            for (int k = 0; k < CHUNK_WORDS; k++)
                issue(random_instr());
        end

        cmd_valid <= 1'b0;
        @(posedge clk);
        wait (expected_left == 0);
        // let any stray response word show up
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("arm_subtract_alu_with_flags_core test passed");
        else
            $display("arm_subtract_alu_with_flags_core test failed");
        $finish;
    end

endmodule
